>>> rtl/core/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg: shared types and constants for the bounded array list engine
// Op codes, status codes, default depth, request struct for the data path.
// ----------------------------------------------------------------------------
package bale_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [3:0] OP_INSERT     = 4'd2;
    localparam logic [3:0] OP_REMOVE_AT  = 4'd3;
    localparam logic [3:0] OP_REMOVE_VAL = 4'd4;
    localparam logic [3:0] OP_POP_FRONT  = 4'd5;
    localparam logic [3:0] OP_POP_BACK   = 4'd6;
    localparam logic [3:0] OP_CLEAR      = 4'd7;
    localparam logic [3:0] OP_FIRST_IDX  = 4'd8;
    localparam logic [3:0] OP_LAST_IDX   = 4'd9;
    localparam logic [3:0] OP_REVERSE    = 4'd10;
    localparam logic [3:0] OP_SORT_ASC   = 4'd11;
    localparam logic [3:0] OP_SORT_DESC  = 4'd12;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // found_index when no match (-1)
    localparam logic [6:0] IDX_NONE = 7'h7F;

    // compare unit request: signed less-than and equality on two words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } cmp_req_t;

    typedef struct packed {
        logic lt;   // a < b, signed
        logic eq;
    } cmp_res_t;

endpackage

>>> rtl/core/bale_cmp.sv
// ----------------------------------------------------------------------------
// bale_cmp: shared word comparator
// Signed less-than and equality, used by search, remove and sort.
// ----------------------------------------------------------------------------
module bale_cmp
(
    input  bale_pkg::cmp_req_t req,
    output bale_pkg::cmp_res_t res
);

    assign res.lt = $signed(req.a) < $signed(req.b);
    assign res.eq = req.a == req.b;

endmodule

>>> rtl/core/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine: fixed-capacity ordered list of signed words
// Sequencer walking a one-read one-write word store with one shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: op, position, operand_value, read_request.
//   m_axis returns one result item per command: status, read_data,
//   found_index, element_count.
//   s_axis_tready is high only while the sequencer is idle; one item is
//   worked at a time. The store is read one word a cycle with the read data
//   registered, so a walk reads each element it visits before it can use it.
//   Push_back, pop_back, clear and refused items need no walk, and a read
//   waits for its registered word. Insert, push_front, remove, pop_front,
//   remove_value, search and reverse walk the list, and the insertion sort
//   walks back from each key in turn.
//   The result sits in an output register; while the receiver stalls the
//   block holds it and takes no new item. Reset clears count and control;
//   the store itself is undefined until written and needs no clearing.
// ----------------------------------------------------------------------------
module bounded_array_list_engine
#(
    parameter int DEPTH = bale_pkg::DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] op, [10:4] position, [42:11] operand_value, [43] read_request
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] read_data, [40:34] found_index, [47:41] element_count
    output logic [47:0] m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // read issued, wait data
    localparam logic [3:0] S_SHR   = 4'd2;  // open gap: read i-1
    localparam logic [3:0] S_SHRW  = 4'd3;  // write i
    localparam logic [3:0] S_SHL   = 4'd4;  // close gap / compact: read i
    localparam logic [3:0] S_SHLW  = 4'd5;
    localparam logic [3:0] S_SRCH  = 4'd6;
    localparam logic [3:0] S_SRCHW = 4'd7;
    localparam logic [3:0] S_REVA  = 4'd8;
    localparam logic [3:0] S_REVB  = 4'd9;
    localparam logic [3:0] S_REVW  = 4'd10;
    localparam logic [3:0] S_SKEY  = 4'd11; // sort: read key at i
    localparam logic [3:0] S_SPRV  = 4'd12; // sort: read j-1
    localparam logic [3:0] S_SCMP  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic [31:0]   tmp_reg, tmp_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   rdd_reg, rdd_next;
    logic [6:0]    fnd_reg, fnd_next;
    logic          ovalid_reg, ovalid_next;

    logic [31:0] mem [DEPTH];
    logic [31:0] q_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    bale_pkg::cmp_req_t creq;
    bale_pkg::cmp_res_t cres;
    bale_cmp u_cmp (.req(creq), .res(cres));

    logic [3:0]    in_op;
    logic [6:0]    in_pos;
    logic [31:0]   in_val;
    logic          in_rd;
    logic [CW-1:0] pos_c;
    logic          pos_big;

    assign in_op  = s_axis_tdata[3:0];
    assign in_pos = s_axis_tdata[10:4];
    assign in_val = s_axis_tdata[42:11];
    assign in_rd  = s_axis_tdata[43];
    // position wider than the count field cannot index the list
    always_comb
    begin
        if (CW >= 7)
        begin
            pos_c   = CW'(in_pos);
            pos_big = 1'b0;
        end
        else
        begin
            pos_c   = CW'(in_pos);
            pos_big = (in_pos >> CW) != 7'd0;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'(count_reg), fnd_reg, rdd_reg, st_reg};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        w_next      = w_reg;
        tmp_next    = tmp_reg;
        st_next     = st_reg;
        rdd_next    = rdd_reg;
        fnd_next    = fnd_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = val_reg;
        raddr       = '0;
        creq.a      = q_reg;
        creq.b      = val_reg;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    op_next  = in_op;
                    val_next = in_val;
                    st_next  = bale_pkg::ST_OK;
                    rdd_next = '0;
                    fnd_next = bale_pkg::IDX_NONE;
                    state_next = S_OUT;
                    if (in_rd)
                    begin
                        if (!pos_big && pos_c < count_reg)
                        begin
                            raddr      = pos_c[AW-1:0];
                            state_next = S_RD;
                        end
                        else
                        begin
                            st_next = bale_pkg::ST_RANGE;
                        end
                    end
                    else
                    begin
                        unique case (in_op)
                            bale_pkg::OP_PUSH_BACK:
                            begin
                                if (count_reg == CW'(DEPTH))
                                begin
                                    st_next = bale_pkg::ST_FULL;
                                end
                                else
                                begin
                                    we         = 1'b1;
                                    waddr      = count_reg[AW-1:0];
                                    wdata      = in_val;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            bale_pkg::OP_PUSH_FRONT, bale_pkg::OP_INSERT:
                            begin
                                if (in_op == bale_pkg::OP_INSERT
                                    && (pos_big || pos_c > count_reg))
                                begin
                                    st_next = bale_pkg::ST_RANGE;
                                end
                                else if (count_reg == CW'(DEPTH))
                                begin
                                    st_next = bale_pkg::ST_FULL;
                                end
                                else
                                begin
                                    j_next = (in_op == bale_pkg::OP_INSERT) ? pos_c : '0;
                                    i_next = count_reg;
                                    state_next = S_SHR;
                                end
                            end
                            bale_pkg::OP_REMOVE_AT, bale_pkg::OP_POP_FRONT:
                            begin
                                if (in_op == bale_pkg::OP_POP_FRONT && count_reg == '0)
                                begin
                                    st_next = bale_pkg::ST_EMPTY;
                                end
                                else if (in_op == bale_pkg::OP_REMOVE_AT
                                         && (pos_big || pos_c >= count_reg))
                                begin
                                    st_next = bale_pkg::ST_RANGE;
                                end
                                else
                                begin
                                    // compaction that drops exactly one slot
                                    i_next = (in_op == bale_pkg::OP_REMOVE_AT) ? pos_c : '0;
                                    w_next = (in_op == bale_pkg::OP_REMOVE_AT) ? pos_c : '0;
                                    j_next = i_next + 1'b1;
                                    i_next = j_next;
                                    state_next = S_SHL;
                                end
                            end
                            bale_pkg::OP_REMOVE_VAL:
                            begin
                                i_next = '0;
                                w_next = '0;
                                state_next = S_SHL;
                            end
                            bale_pkg::OP_POP_BACK:
                            begin
                                if (count_reg == '0)
                                begin
                                    st_next = bale_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            bale_pkg::OP_CLEAR:
                            begin
                                count_next = '0;
                            end
                            bale_pkg::OP_FIRST_IDX:
                            begin
                                i_next = '0;
                                state_next = S_SRCH;
                            end
                            bale_pkg::OP_LAST_IDX:
                            begin
                                i_next = count_reg;
                                state_next = S_SRCH;
                            end
                            bale_pkg::OP_REVERSE:
                            begin
                                i_next = '0;
                                j_next = count_reg;
                                state_next = S_REVA;
                            end
                            bale_pkg::OP_SORT_ASC, bale_pkg::OP_SORT_DESC:
                            begin
                                i_next = CW'(1);
                                state_next = S_SKEY;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next  = S_IDLE;
                ovalid_next = 1'b1;
            end
            // open gap: i walks down from count to j
            S_SHR:
            begin
                if (i_reg == j_reg)
                begin
                    we         = 1'b1;
                    waddr      = j_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = AW'(i_reg - 1'b1);
                    state_next = S_SHRW;
                end
            end
            S_SHRW:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = q_reg;
                i_next     = i_reg - 1'b1;
                state_next = S_SHR;
            end
            // compaction: i reads, w writes
            S_SHL:
            begin
                if (i_reg >= count_reg)
                begin
                    count_next = w_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    state_next = S_SHLW;
                end
            end
            S_SHLW:
            begin
                if (op_reg != bale_pkg::OP_REMOVE_VAL || !cres.eq)
                begin
                    we     = 1'b1;
                    waddr  = w_reg[AW-1:0];
                    wdata  = q_reg;
                    w_next = w_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_SHL;
            end
            S_SRCH:
            begin
                if ((op_reg == bale_pkg::OP_FIRST_IDX && i_reg >= count_reg)
                    || (op_reg == bale_pkg::OP_LAST_IDX && i_reg == '0))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    raddr = (op_reg == bale_pkg::OP_FIRST_IDX)
                            ? i_reg[AW-1:0] : AW'(i_reg - 1'b1);
                    state_next = S_SRCHW;
                end
            end
            S_SRCHW:
            begin
                if (cres.eq)
                begin
                    fnd_next = (op_reg == bale_pkg::OP_FIRST_IDX)
                               ? 7'(i_reg) : 7'(i_reg - 1'b1);
                    state_next = S_OUT;
                end
                else
                begin
                    i_next = (op_reg == bale_pkg::OP_FIRST_IDX)
                             ? i_reg + 1'b1 : i_reg - 1'b1;
                    state_next = S_SRCH;
                end
            end
            // reverse: i from front, j one past back
            S_REVA:
            begin
                if (i_reg + 1'b1 >= j_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    state_next = S_REVB;
                end
            end
            S_REVB:
            begin
                tmp_next   = q_reg;
                raddr      = AW'(j_reg - 1'b1);
                state_next = S_REVW;
            end
            S_REVW:
            begin
                // write back element at i now; the front word goes to j-1 in S_SCMP
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = q_reg;
                val_next   = tmp_reg;
                tmp_next   = tmp_reg;
                state_next = S_SCMP;
                op_next    = op_reg;
            end
            S_SKEY:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    j_next     = i_reg;
                    state_next = S_SPRV;
                end
            end
            S_SPRV:
            begin
                if (j_reg == i_reg)
                begin
                    tmp_next = q_reg;
                end
                if (j_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = (j_reg == i_reg) ? q_reg : tmp_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SKEY;
                end
                else
                begin
                    raddr      = AW'(j_reg - 1'b1);
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (op_reg == bale_pkg::OP_REVERSE)
                begin
                    // finish swap: old front word to j-1
                    we         = 1'b1;
                    waddr      = AW'(j_reg - 1'b1);
                    wdata      = tmp_reg;
                    i_next     = i_reg + 1'b1;
                    j_next     = j_reg - 1'b1;
                    state_next = S_REVA;
                end
                else
                begin
                    creq.a = (op_reg == bale_pkg::OP_SORT_DESC) ? q_reg : tmp_reg;
                    creq.b = (op_reg == bale_pkg::OP_SORT_DESC) ? tmp_reg : q_reg;
                    we     = 1'b1;
                    waddr  = j_reg[AW-1:0];
                    if (cres.lt)
                    begin
                        wdata      = q_reg;
                        j_next     = j_reg - 1'b1;
                        state_next = S_SPRV;
                    end
                    else
                    begin
                        wdata      = tmp_reg;
                        i_next     = i_reg + 1'b1;
                        state_next = S_SKEY;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_RD)
        begin
            rdd_next = q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        w_reg   <= w_next;
        tmp_reg <= tmp_next;
        st_reg  <= st_next;
        rdd_reg <= rdd_next;
        fnd_reg <= fnd_next;
    end

endmodule
